// ===== hdl/stt_pkg.sv =====
// stt_pkg: shared types and constants for the software timer table
// opcodes, result kinds, field widths and controller/datapath interface structs
// no dependencies
`default_nettype none

package stt_pkg;

  localparam int NUM_SLOTS_DEF = 8;
  localparam int OP_W          = 2;
  localparam int KIND_W        = 3;
  localparam int TIME_W        = 32;
  localparam int ID_W          = 32;
  localparam int CNT_OUT_W     = 4;

  typedef enum logic [OP_W-1:0] {
    OP_SCHED  = 2'd0,
    OP_CANCEL = 2'd1,
    OP_PROC   = 2'd2,
    OP_CLEAR  = 2'd3
  } op_t;

  typedef enum logic [KIND_W-1:0] {
    KIND_SCHED  = 3'd0,
    KIND_CANCEL = 3'd1,
    KIND_FIRED  = 3'd2,
    KIND_DONE   = 3'd3,
    KIND_CLEAR  = 3'd4
  } kind_t;

  typedef struct packed {
    logic load;
    logic step;
    logic slot_upd;
    logic finish;
  } stt_cmd_t;

  typedef struct packed {
    logic hit;
    logic hit_ends;
    logic skip_scan;
    logic last_idx;
    logic out_free;
  } stt_sts_t;

endpackage

`default_nettype wire

// ===== hdl/stt_ctrl.sv =====
// stt_ctrl: sequencer for the software timer table
// walks the slot scan and orders result transfers; uses stt_pkg
`default_nettype none

module stt_ctrl (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire stt_pkg::stt_sts_t sts,
  output stt_pkg::stt_cmd_t      cmd
);
  import stt_pkg::*;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_FINISH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_SCAN;
        end
      end
      S_SCAN: begin
        if (sts.skip_scan) begin
          state_nxt = S_FINISH;
        end else if (sts.hit) begin
          if (sts.out_free) begin
            cmd.slot_upd = 1'b1;
            if (sts.hit_ends) begin
              state_nxt = S_IDLE;
            end else if (sts.last_idx) begin
              state_nxt = S_FINISH;
            end else begin
              cmd.step = 1'b1;
            end
          end
        end else if (sts.last_idx) begin
          state_nxt = S_FINISH;
        end else begin
          cmd.step = 1'b1;
        end
      end
      S_FINISH: begin
        if (sts.out_free) begin
          cmd.finish = 1'b1;
          state_nxt  = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= S_IDLE;
      in_stall_r <= 1'b0;
    end else begin
      state_r    <= state_nxt;
      in_stall_r <= (state_nxt != S_IDLE);
    end
  end

  assign in_stall = in_stall_r;

endmodule

`default_nettype wire

// ===== hdl/stt_datapath.sv =====
// stt_datapath: slot storage, scan index, counters and result register
// acts on commands from stt_ctrl and reports status; uses stt_pkg
`default_nettype none

module stt_datapath #(
  parameter int NUM_SLOTS = stt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic [stt_pkg::OP_W-1:0]       in_opcode,
  input  wire logic [stt_pkg::TIME_W-1:0]     in_now_ms,
  input  wire logic [stt_pkg::TIME_W-1:0]     in_interval_ms,
  input  wire logic                           in_periodic,
  input  wire logic [stt_pkg::ID_W-1:0]       in_target_id,
  input  wire stt_pkg::stt_cmd_t              cmd,
  output stt_pkg::stt_sts_t                   sts,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [stt_pkg::KIND_W-1:0]          out_kind,
  output logic                                out_ok,
  output logic [stt_pkg::ID_W-1:0]            out_tid,
  output logic [stt_pkg::CNT_OUT_W-1:0]       out_fire_cnt,
  output logic [stt_pkg::CNT_OUT_W-1:0]       out_active_count,
  output logic                                out_last
);
  import stt_pkg::*;

  localparam int IDX_W = (NUM_SLOTS > 1) ? $clog2(NUM_SLOTS) : 1;
  localparam int CNT_W = $clog2(NUM_SLOTS + 1);

  // latched item
  op_t               op_r;
  logic [TIME_W-1:0] now_r;
  logic [TIME_W-1:0] ivl_r;
  logic              per_r;
  logic [ID_W-1:0]   tgt_r;

  // slot table
  logic [NUM_SLOTS-1:0] active_r, active_nxt;
  logic [ID_W-1:0]      slot_id_r   [NUM_SLOTS];
  logic [TIME_W-1:0]    slot_ivl_r  [NUM_SLOTS];
  logic [TIME_W-1:0]    slot_fire_r [NUM_SLOTS];
  logic                 slot_per_r  [NUM_SLOTS];

  logic [IDX_W-1:0] idx_r, idx_nxt;
  logic [CNT_W-1:0] used_r, used_nxt;
  logic [CNT_W-1:0] fired_r, fired_nxt;
  logic [ID_W-1:0]  next_id_r, next_id_nxt;

  // result register
  logic                 out_valid_r, out_valid_nxt;
  kind_t                out_kind_r, o_kind_nxt;
  logic                 out_ok_r, o_ok_nxt;
  logic [ID_W-1:0]      out_id_r, o_id_nxt;
  logic [CNT_OUT_W-1:0] out_fired_r, o_fired_nxt;
  logic [CNT_OUT_W-1:0] out_active_r, o_active_nxt;
  logic                 out_last_r, o_last_nxt;
  logic                 emit;

  logic [ID_W-1:0]   cur_id;
  logic [TIME_W-1:0] cur_ivl;
  logic [TIME_W-1:0] cur_fire;
  logic              cur_per;
  logic              cur_act;
  logic [TIME_W-1:0] fire_sum;
  logic              sched_ok;

  assign cur_id   = slot_id_r[idx_r];
  assign cur_ivl  = slot_ivl_r[idx_r];
  assign cur_fire = slot_fire_r[idx_r];
  assign cur_per  = slot_per_r[idx_r];
  assign cur_act  = active_r[idx_r];
  assign fire_sum = now_r + ((op_r == OP_SCHED) ? ivl_r : cur_ivl);
  assign sched_ok = (ivl_r != '0) && (used_r < CNT_W'(NUM_SLOTS)) && (next_id_r != '0);

  always_comb begin
    sts           = '0;
    sts.hit_ends  = (op_r != OP_PROC);
    sts.skip_scan = (op_r == OP_CLEAR) || ((op_r == OP_SCHED) && !sched_ok);
    sts.last_idx  = (idx_r == IDX_W'(NUM_SLOTS - 1));
    sts.out_free  = !out_valid_r || !out_stall;
    case (op_r)
      OP_SCHED:  sts.hit = sched_ok && !cur_act;
      OP_CANCEL: sts.hit = cur_act && (tgt_r != '0) && (cur_id == tgt_r);
      OP_PROC:   sts.hit = cur_act && (now_r >= cur_fire);
      default:   sts.hit = 1'b0;
    endcase
  end

  always_comb begin
    active_nxt   = active_r;
    used_nxt     = used_r;
    next_id_nxt  = next_id_r;
    fired_nxt    = fired_r;
    idx_nxt      = idx_r;
    emit         = 1'b0;
    o_kind_nxt   = KIND_SCHED;
    o_ok_nxt     = 1'b0;
    o_id_nxt     = '0;
    o_fired_nxt  = '0;
    o_active_nxt = '0;
    o_last_nxt   = 1'b1;
    if (cmd.load) begin
      idx_nxt   = '0;
      fired_nxt = '0;
    end
    if (cmd.step) begin
      idx_nxt = idx_r + IDX_W'(1);
    end
    if (cmd.slot_upd) begin
      emit     = 1'b1;
      o_ok_nxt = 1'b1;
      case (op_r)
        OP_SCHED: begin
          active_nxt[idx_r] = 1'b1;
          used_nxt          = used_r + CNT_W'(1);
          next_id_nxt       = next_id_r + ID_W'(1);
          o_kind_nxt        = KIND_SCHED;
          o_id_nxt          = next_id_r;
        end
        OP_CANCEL: begin
          active_nxt[idx_r] = 1'b0;
          used_nxt          = used_r - CNT_W'(1);
          o_kind_nxt        = KIND_CANCEL;
        end
        OP_PROC: begin
          fired_nxt = fired_r + CNT_W'(1);
          if (!cur_per) begin
            active_nxt[idx_r] = 1'b0;
            used_nxt          = used_r - CNT_W'(1);
          end
          o_kind_nxt  = KIND_FIRED;
          o_id_nxt    = cur_id;
          o_fired_nxt = CNT_OUT_W'(fired_nxt);
          o_last_nxt  = 1'b0;
        end
        default: ;
      endcase
      o_active_nxt = CNT_OUT_W'(used_nxt);
    end
    if (cmd.finish) begin
      emit = 1'b1;
      case (op_r)
        OP_SCHED: begin
          o_kind_nxt = KIND_SCHED;
          o_ok_nxt   = 1'b0;
        end
        OP_CANCEL: begin
          o_kind_nxt = KIND_CANCEL;
          o_ok_nxt   = 1'b0;
        end
        OP_PROC: begin
          o_kind_nxt  = KIND_DONE;
          o_ok_nxt    = 1'b1;
          o_fired_nxt = CNT_OUT_W'(fired_r);
        end
        default: begin
          active_nxt = '0;
          used_nxt   = '0;
          o_kind_nxt = KIND_CLEAR;
          o_ok_nxt   = 1'b1;
        end
      endcase
      o_active_nxt = CNT_OUT_W'(used_nxt);
    end
    out_valid_nxt = emit || (out_valid_r && out_stall);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r    <= '0;
      used_r      <= '0;
      next_id_r   <= ID_W'(1);
      fired_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      active_r    <= active_nxt;
      used_r      <= used_nxt;
      next_id_r   <= next_id_nxt;
      fired_r     <= fired_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // item latch, slot payload and result payload
  always_ff @(posedge clk) begin
    if (cmd.load) begin
      op_r  <= op_t'(in_opcode);
      now_r <= in_now_ms;
      ivl_r <= in_interval_ms;
      per_r <= in_periodic;
      tgt_r <= in_target_id;
    end
    if (cmd.slot_upd) begin
      case (op_r)
        OP_SCHED: begin
          slot_id_r[idx_r]   <= next_id_r;
          slot_ivl_r[idx_r]  <= ivl_r;
          slot_fire_r[idx_r] <= fire_sum;
          slot_per_r[idx_r]  <= per_r;
        end
        OP_PROC: begin
          if (cur_per) begin
            slot_fire_r[idx_r] <= fire_sum;
          end
        end
        default: ;
      endcase
    end
    if (emit) begin
      out_kind_r   <= o_kind_nxt;
      out_ok_r     <= o_ok_nxt;
      out_id_r     <= o_id_nxt;
      out_fired_r  <= o_fired_nxt;
      out_active_r <= o_active_nxt;
      out_last_r   <= o_last_nxt;
    end
  end

  assign out_valid        = out_valid_r;
  assign out_kind         = out_kind_r;
  assign out_ok           = out_ok_r;
  assign out_tid          = out_id_r;
  assign out_fire_cnt     = out_fired_r;
  assign out_active_count = out_active_r;
  assign out_last         = out_last_r;

endmodule

`default_nettype wire

// ===== hdl/software_timer_table.sv =====
// software_timer_table: top level of the timer slot table
// joins stt_ctrl and stt_datapath; uses stt_pkg
//
// Usage: one input channel (in_*) carries schedule, cancel, process and clear
// items; the result channel (out_*) returns one result per schedule, cancel
// and clear item, and for a process item one "fired" result per due slot in
// slot order followed by a "done" result. out_last marks the final result of
// an item. Both channels transfer when valid is high and stall is low.
// Items are handled one at a time: in_stall rises the cycle after a transfer
// and drops once the last result is in the output register. The slot scan
// visits one slot per cycle, and schedule, cancel and process items scan up
// to NUM_SLOTS slots; clear and a rejected schedule skip the scan. A
// schedule or cancel finishes at the slot that matches. When out_stall is
// high the scan holds on the slot that has a result waiting and resumes
// once the output register drains. Reset empties all slots, sets the id
// counter to 1 and drops out_valid; no sweep of the slot storage is needed.
`default_nettype none

module software_timer_table #(
  parameter int NUM_SLOTS = stt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_valid,
  output logic                                in_stall,
  input  wire logic [stt_pkg::OP_W-1:0]       in_opcode,
  input  wire logic [stt_pkg::TIME_W-1:0]     in_now_ms,
  input  wire logic [stt_pkg::TIME_W-1:0]     in_interval_ms,
  input  wire logic                           in_periodic,
  input  wire logic [stt_pkg::ID_W-1:0]       in_target_id,
  output logic                                out_valid,
  input  wire logic                           out_stall,
  output logic [stt_pkg::KIND_W-1:0]          out_kind,
  output logic                                out_ok,
  output logic [stt_pkg::ID_W-1:0]            out_tid,
  output logic [stt_pkg::CNT_OUT_W-1:0]       out_fire_cnt,
  output logic [stt_pkg::CNT_OUT_W-1:0]       out_active_count,
  output logic                                out_last
);
  import stt_pkg::*;

  stt_cmd_t cmd;
  stt_sts_t sts;

  stt_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .sts      (sts),
    .cmd      (cmd)
  );

  stt_datapath #(
    .NUM_SLOTS (NUM_SLOTS)
  ) u_datapath (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_opcode        (in_opcode),
    .in_now_ms        (in_now_ms),
    .in_interval_ms   (in_interval_ms),
    .in_periodic      (in_periodic),
    .in_target_id     (in_target_id),
    .cmd              (cmd),
    .sts              (sts),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_ok           (out_ok),
    .out_tid          (out_tid),
    .out_fire_cnt     (out_fire_cnt),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

  a_one_emit: assert property (@(posedge clk) disable iff (!rst_n)
    !(cmd.slot_upd && cmd.finish))
    else $error("slot update and finish in the same cycle");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.slot_upd || cmd.finish) |-> sts.out_free)
    else $error("result written over a pending transfer");

  a_idle_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    !in_stall |-> !(cmd.slot_upd || cmd.finish || cmd.step))
    else $error("scan activity while idle");

  a_busy_after_in: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && !in_stall) |=> in_stall)
    else $error("input not held off after transfer");

  a_fired_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && (out_kind == KIND_FIRED)) |-> !out_last)
    else $error("fired result marked last");

endmodule

`default_nettype wire

// ===== test/software_timer_table_checker.sv =====
// software_timer_table_checker: watches both channels of the timer table, predicts
// the replies of every accepted request and compares each reply field by field
// uses stt_pkg; instantiated beside the block by software_timer_table_test
module software_timer_table_checker #(
  parameter int NSLOT = stt_pkg::NUM_SLOTS_DEF
) (
  input  wire logic                          clk,
  input  wire logic                          rst_n,
  input  wire logic                          in_valid,
  input  wire logic                          in_stall,
  input  wire logic [stt_pkg::OP_W-1:0]      in_opcode,
  input  wire logic [stt_pkg::TIME_W-1:0]    in_now_ms,
  input  wire logic [stt_pkg::TIME_W-1:0]    in_interval_ms,
  input  wire logic                          in_periodic,
  input  wire logic [stt_pkg::ID_W-1:0]      in_target_id,
  input  wire logic                          out_valid,
  input  wire logic                          out_stall,
  input  wire logic [stt_pkg::KIND_W-1:0]    out_kind,
  input  wire logic                          out_ok,
  input  wire logic [stt_pkg::ID_W-1:0]      out_tid,
  input  wire logic [stt_pkg::CNT_OUT_W-1:0] out_fire_cnt,
  input  wire logic [stt_pkg::CNT_OUT_W-1:0] out_active_count,
  input  wire logic                          out_last,
  output int                                 errors,
  output int                                 replies_owed,
  output logic [stt_pkg::ID_W-1:0]           newest_id
);
  import stt_pkg::*;

  typedef struct packed {
    kind_t                kind;
    logic                 ok;
    logic [ID_W-1:0]      tid;
    logic [CNT_OUT_W-1:0] fires;
    logic [CNT_OUT_W-1:0] live_n;
    logic                 last;
  } timer_reply_t;

  logic              live   [NSLOT];
  logic [ID_W-1:0]   tag    [NSLOT];
  logic [TIME_W-1:0] span   [NSLOT];
  logic [TIME_W-1:0] due_at [NSLOT];
  logic              rearm  [NSLOT];
  int                live_cnt;
  logic [ID_W-1:0]   id_next;
  timer_reply_t      timer_replies [$];
  int                mismatches;

  initial begin
    errors = 0;
    replies_owed = 0;
    newest_id = '0;
    mismatches = 0;
    live_cnt = 0;
    id_next = 1;
    for (int s = 0; s < NSLOT; s++) live[s] = 1'b0;
  end

  function automatic void note_reply(kind_t k, logic ok, logic [ID_W-1:0] tid, int fires,
                                     logic last);
    timer_reply_t r;
    r.kind   = k;
    r.ok     = ok;
    r.tid    = tid;
    r.fires  = CNT_OUT_W'(fires);
    r.live_n = CNT_OUT_W'(live_cnt);
    r.last   = last;
    timer_replies.push_back(r);
  endfunction

  function automatic void apply_timer_op(op_t op, logic [TIME_W-1:0] now,
                                         logic [TIME_W-1:0] ivl, logic per,
                                         logic [ID_W-1:0] tgt);
    int   fires;
    logic hit;
    fires = 0;
    hit = 1'b0;
    case (op)
      OP_SCHED: begin
        if (ivl == 0 || live_cnt >= NSLOT || id_next == 0) begin
          note_reply(KIND_SCHED, 1'b0, '0, 0, 1'b1);
        end else begin
          for (int s = 0; s < NSLOT; s++) begin
            if (!hit && !live[s]) begin
              hit       = 1'b1;
              live[s]   = 1'b1;
              tag[s]    = id_next;
              span[s]   = ivl;
              due_at[s] = now + ivl;
              rearm[s]  = per;
              live_cnt++;
            end
          end
          note_reply(KIND_SCHED, 1'b1, id_next, 0, 1'b1);
          id_next = id_next + 1;
        end
      end
      OP_CANCEL: begin
        for (int s = 0; s < NSLOT; s++) begin
          if (!hit && tgt != 0 && live[s] && tag[s] == tgt) begin
            hit     = 1'b1;
            live[s] = 1'b0;
            live_cnt--;
          end
        end
        note_reply(KIND_CANCEL, hit, '0, 0, 1'b1);
      end
      OP_PROC: begin
        for (int s = 0; s < NSLOT; s++) begin
          if (live[s] && now >= due_at[s]) begin
            fires++;
            if (rearm[s]) begin
              due_at[s] = now + span[s];
            end else begin
              live[s] = 1'b0;
              live_cnt--;
            end
            note_reply(KIND_FIRED, 1'b1, tag[s], fires, 1'b0);
          end
        end
        note_reply(KIND_DONE, 1'b1, '0, fires, 1'b1);
      end
      default: begin
        for (int s = 0; s < NSLOT; s++) live[s] = 1'b0;
        live_cnt = 0;
        note_reply(KIND_CLEAR, 1'b1, '0, 0, 1'b1);
      end
    endcase
  endfunction

  function automatic void check_field(string name, logic [ID_W-1:0] exp_v,
                                      logic [ID_W-1:0] got_v);
    if (exp_v !== got_v) begin
      mismatches++;
      $display("%0t: %s expected %h actual %h", $time, name, exp_v, got_v);
    end
  endfunction

  always @(posedge clk) begin
    timer_reply_t want;
    if (!rst_n) begin
      for (int s = 0; s < NSLOT; s++) live[s] = 1'b0;
      live_cnt = 0;
      id_next = 1;
      timer_replies.delete();
    end else begin
      if (out_valid && !out_stall) begin
        if (timer_replies.size() == 0) begin
          mismatches++;
          $display("%0t: unexpected reply transfer, kind %0d id %h", $time, out_kind,
                   out_tid);
        end else begin
          want = timer_replies.pop_front();
          check_field("kind", ID_W'(want.kind), ID_W'(out_kind));
          check_field("ok", ID_W'(want.ok), ID_W'(out_ok));
          check_field("tid", want.tid, out_tid);
          check_field("fire_cnt", ID_W'(want.fires), ID_W'(out_fire_cnt));
          check_field("active_count", ID_W'(want.live_n), ID_W'(out_active_count));
          check_field("last", ID_W'(want.last), ID_W'(out_last));
        end
      end
      if (in_valid && !in_stall) begin
        apply_timer_op(op_t'(in_opcode), in_now_ms, in_interval_ms, in_periodic,
                       in_target_id);
      end
    end
    errors <= mismatches;
    replies_owed <= timer_replies.size();
    newest_id <= id_next - 1;
  end

endmodule

// ===== test/software_timer_table_test.sv =====
// software_timer_table_test: top of the timer table testbench; drives directed and
// random requests with random idling and a long reply hold-off, and gives the verdict
// uses stt_pkg, software_timer_table and software_timer_table_checker
module software_timer_table_test;
  import stt_pkg::*;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_stall;
  logic [OP_W-1:0]      in_opcode;
  logic [TIME_W-1:0]    in_now_ms;
  logic [TIME_W-1:0]    in_interval_ms;
  logic                 in_periodic;
  logic [ID_W-1:0]      in_target_id;
  logic                 out_valid;
  logic                 out_stall;
  logic [KIND_W-1:0]    out_kind;
  logic                 out_ok;
  logic [ID_W-1:0]      out_tid;
  logic [CNT_OUT_W-1:0] out_fire_cnt;
  logic [CNT_OUT_W-1:0] out_active_count;
  logic                 out_last;

  int                   fail_count;
  int                   replies_owed;
  logic [ID_W-1:0]      newest_id;
  bit                   calm;
  bit                   sender_gaps;
  bit                   long_hold_req;
  int                   stall_left;
  logic [TIME_W-1:0]    wall_ms;

  software_timer_table i_dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_now_ms        (in_now_ms),
    .in_interval_ms   (in_interval_ms),
    .in_periodic      (in_periodic),
    .in_target_id     (in_target_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_ok           (out_ok),
    .out_tid          (out_tid),
    .out_fire_cnt     (out_fire_cnt),
    .out_active_count (out_active_count),
    .out_last         (out_last)
  );

  software_timer_table_checker i_checker (
    .clk              (clk),
    .rst_n            (rst_n),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .in_opcode        (in_opcode),
    .in_now_ms        (in_now_ms),
    .in_interval_ms   (in_interval_ms),
    .in_periodic      (in_periodic),
    .in_target_id     (in_target_id),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .out_kind         (out_kind),
    .out_ok           (out_ok),
    .out_tid          (out_tid),
    .out_fire_cnt     (out_fire_cnt),
    .out_active_count (out_active_count),
    .out_last         (out_last),
    .errors           (fail_count),
    .replies_owed     (replies_owed),
    .newest_id        (newest_id)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #20000000;
    $display("RESULT: ERROR");
    $finish;
  end

  // reply side: short random hold-offs, one long one on request
  initial begin
    out_stall = 1'b0;
    stall_left = 0;
    forever begin
      @(negedge clk);
      if (stall_left > 0) begin
        stall_left--;
      end else if (long_hold_req) begin
        long_hold_req = 1'b0;
        stall_left = 250;
      end else if (!calm && $urandom_range(0, 6) == 0) begin
        stall_left = $urandom_range(1, 14);
      end
      out_stall = (stall_left > 0);
    end
  end

  // entered right after a falling edge, returns right after one
  task automatic offer(input op_t op, input logic [TIME_W-1:0] now,
                       input logic [TIME_W-1:0] ivl, input logic per,
                       input logic [ID_W-1:0] tgt);
    in_valid       = 1'b1;
    in_opcode      = op;
    in_now_ms      = now;
    in_interval_ms = ivl;
    in_periodic    = per;
    in_target_id   = tgt;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    @(negedge clk);
    if (!calm && sender_gaps && $urandom_range(0, 2) == 0) begin
      in_valid = 1'b0;
      repeat ($urandom_range(1, 14)) @(negedge clk);
    end
  endtask

  initial begin
    op_t               op;
    logic [TIME_W-1:0] now;
    logic [TIME_W-1:0] ivl;
    logic [ID_W-1:0]   tgt;
    logic              per;
    int                r;
    rst_n          = 1'b0;
    in_valid       = 1'b0;
    in_opcode      = OP_SCHED;
    in_now_ms      = '0;
    in_interval_ms = '0;
    in_periodic    = 1'b0;
    in_target_id   = '0;
    calm           = 1'b0;
    sender_gaps    = 1'b1;
    long_hold_req  = 1'b0;
    wall_ms        = 1000;
    repeat (6) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    // empty table, bad cancels, zero interval
    offer(OP_PROC, 32'h0, 32'h0, 1'b0, 32'h0);
    offer(OP_CANCEL, 32'h0, 32'h0, 1'b0, 32'h0);
    offer(OP_CANCEL, 32'h0, 32'h0, 1'b0, 32'hFFFF_FFFF);
    offer(OP_SCHED, 32'h0, 32'h0, 1'b1, 32'h0);
    // fire time wraps past zero
    offer(OP_SCHED, 32'hFFFF_FFF0, 32'h20, 1'b1, 32'h0);
    offer(OP_PROC, 32'h0F, 32'h0, 1'b0, 32'h0);
    offer(OP_PROC, 32'h10, 32'h0, 1'b0, 32'h0);
    // fill the table, then one more
    for (int k = 1; k < 8; k++) offer(OP_SCHED, 32'h10, k, k[0], 32'h0);
    offer(OP_SCHED, 32'h10, 32'h5, 1'b0, 32'h0);
    // everything due at once
    offer(OP_PROC, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0);
    offer(OP_CANCEL, 32'h0, 32'h0, 1'b0, 32'h3);
    offer(OP_CANCEL, 32'h0, 32'h0, 1'b0, 32'h4);
    offer(OP_SCHED, 32'h0, 32'hFFFF_FFFF, 1'b0, 32'h0);
    offer(OP_CLEAR, 32'h0, 32'h0, 1'b0, 32'h0);
    offer(OP_CANCEL, 32'h0, 32'h0, 1'b0, 32'h9);
    offer(OP_PROC, 32'hFFFF_FFFF, 32'h0, 1'b0, 32'h0);

    for (int k = 0; k < 388; k++) begin
      if (k == 30) long_hold_req = 1'b1;
      if (k == 330) calm = 1'b1;
      if (k % 40 == 0) sender_gaps = $urandom_range(0, 1);
      wall_ms = wall_ms + $urandom_range(0, 20);
      r = $urandom_range(0, 59);
      if (r == 0) wall_ms = $urandom;
      else if (r == 1) wall_ms = 32'hFFFF_FFFF - $urandom_range(0, 100);
      now = ($urandom_range(0, 11) == 0) ? $urandom : wall_ms;
      r = $urandom_range(0, 19);
      if (r == 0) ivl = '0;
      else if (r < 3) ivl = $urandom;
      else ivl = $urandom_range(1, 60);
      per = $urandom_range(0, 1);
      tgt = $urandom;
      r = $urandom_range(0, 99);
      if (r < 40) begin
        op = OP_SCHED;
      end else if (r < 58) begin
        op = OP_CANCEL;
        r = $urandom_range(0, 9);
        if (r == 0) tgt = '0;
        else if (r > 1) tgt = (newest_id > 12) ? $urandom_range(newest_id - 12, newest_id)
                                               : $urandom_range(1, 12);
      end else if (r < 95) begin
        op = OP_PROC;
      end else begin
        op = OP_CLEAR;
      end
      offer(op, now, ivl, per, tgt);
    end

    in_valid = 1'b0;
    while (replies_owed != 0) @(negedge clk);
    repeat (30) @(negedge clk);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
hdl/stt_pkg.sv
hdl/stt_ctrl.sv
hdl/stt_datapath.sv
hdl/software_timer_table.sv
test/software_timer_table_checker.sv
test/software_timer_table_test.sv
